FILE: design/sync_length_trailer_deframer_macros.svh
// ----------------------------------------------------------------------------
// sync_length_trailer_deframer_macros.svh
// Assertion macros used by the deframer checker. Each macro expects clk
// and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_TRAILER_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_TRAILER_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SLTD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication
`define SLTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

FILE: design/sltd_pkg.sv
// ----------------------------------------------------------------------------
// sltd_pkg
// Types and constants of the sync/length/trailer deframer.
// ----------------------------------------------------------------------------
package sltd_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_VALUE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_TYPE   = 3'd4;

  localparam logic [7:0] RST_SYNC_FIRST    = 8'h55;
  localparam logic [7:0] RST_SYNC_SECOND   = 8'hAA;
  localparam logic [7:0] RST_TRAILER_VALUE = 8'h45;
  localparam logic [7:0] RST_MAX_LENGTH    = 8'd23;
  localparam logic [7:0] RST_TOGGLE_TYPE   = 8'd2;

  localparam logic [7:0] SYNC2_MASK = 8'hFE;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  typedef enum logic [2:0] {
    EV_CONSUMED = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_GOOD     = 3'd2,
    EV_BADTRL   = 3'd3,
    EV_REJECT   = 3'd4
  } sltd_event_t;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_SYNC2   = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_LENGTH  = 6'b001000,
    PH_DATA    = 6'b010000,
    PH_TRAILER = 6'b100000
  } sltd_phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } sltd_item_t;

  typedef struct packed {
    logic       valid;
    sltd_item_t item;
  } sltd_stage_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] trailer_value;
    logic [7:0] max_length;
    logic [7:0] toggle_type;
  } sltd_cfg_t;

endpackage

FILE: design/sltd_in_if.sv
// ----------------------------------------------------------------------------
// sltd_in_if
// Input channel: one received byte or an acknowledge per beat.
// ----------------------------------------------------------------------------
interface sltd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

FILE: design/sltd_out_if.sv
// ----------------------------------------------------------------------------
// sltd_out_if
// Result channel: one parser event per beat.
// ----------------------------------------------------------------------------
interface sltd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic       request_flag;

  modport source (output valid, output event_res, output payload_byte,
                  output payload_index, output frame_type, output frame_length,
                  output request_flag, input ready);
  modport sink   (input valid, input event_res, input payload_byte,
                  input payload_index, input frame_type, input frame_length,
                  input request_flag, output ready);
endinterface

FILE: design/sync_length_trailer_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_trailer_deframer
// Byte-serial frame parser: sync, sync, type, length, payload, trailer.
// ----------------------------------------------------------------------------
//  port    dir  beat contents
//  in_ch   in   opcode, rx_byte
//  out_ch  out  event_res, payload_byte, payload_index, frame_type,
//               frame_length, request_flag
//  cfg_*   in   cfg_we, cfg_index, cfg_wdata (write only)
//
// One beat per cycle sustained while out_ch.ready stays high; a result passes
// through the input register, then the result register.
// Every input beat yields exactly one result beat.
// Synchronous active-low reset clears control state and loads register
// defaults. out_ch.ready low stalls the result register, which then holds
// the input register; in_ch.ready drops once both are full.
// ----------------------------------------------------------------------------
module sync_length_trailer_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  sltd_in_if.sink                        in_ch,
  sltd_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [sltd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import sltd_pkg::*;

  sltd_cfg_t   cfg;
  sltd_stage_t stage;
  logic        advance;

  sltd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sltd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  sltd_parser u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .cfg     (cfg),
    .out_ch  (out_ch),
    .advance (advance)
  );
endmodule

FILE: design/sltd_cfg_regs.sv
// ----------------------------------------------------------------------------
// sltd_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module sltd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sltd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata,
  output sltd_pkg::sltd_cfg_t            cfg
);
  import sltd_pkg::*;

  sltd_cfg_t cfg_r;
  sltd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:    cfg_nxt.sync_first    = cfg_wdata;
        REG_SYNC_SECOND:   cfg_nxt.sync_second   = cfg_wdata;
        REG_TRAILER_VALUE: cfg_nxt.trailer_value = cfg_wdata;
        REG_MAX_LENGTH:    cfg_nxt.max_length    = cfg_wdata;
        REG_TOGGLE_TYPE:   cfg_nxt.toggle_type   = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first    <= RST_SYNC_FIRST;
      cfg_r.sync_second   <= RST_SYNC_SECOND;
      cfg_r.trailer_value <= RST_TRAILER_VALUE;
      cfg_r.max_length    <= RST_MAX_LENGTH;
      cfg_r.toggle_type   <= RST_TOGGLE_TYPE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

FILE: design/sltd_in_stage.sv
// ----------------------------------------------------------------------------
// sltd_in_stage
// Input register: holds one beat until the parser stage takes it.
// ----------------------------------------------------------------------------
module sltd_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  sltd_in_if.sink               in_ch,
  input  logic                  advance,
  output sltd_pkg::sltd_stage_t stage
);
  import sltd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  sltd_item_t item_r;
  logic       accept;

  assign in_ch.ready = !valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.opcode  <= in_ch.opcode;
      item_r.rx_byte <= in_ch.rx_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;
endmodule

FILE: design/sltd_parser.sv
// ----------------------------------------------------------------------------
// sltd_parser
// Frame state machine and result register.
// ----------------------------------------------------------------------------
module sltd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sltd_pkg::sltd_stage_t stage,
  input  sltd_pkg::sltd_cfg_t   cfg,
  sltd_out_if.source            out_ch,
  output logic                  advance
);
  import sltd_pkg::*;

  sltd_phase_t phase_r,    phase_nxt;
  logic [7:0]  sync2_r,    sync2_nxt;
  logic [7:0]  type_r,     type_nxt;
  logic [7:0]  length_r,   length_nxt;
  logic [7:0]  count_r,    count_nxt;
  logic        req_r,      req_nxt;

  logic        out_valid_r, out_valid_nxt;
  sltd_event_t ev_r,        ev_nxt;
  logic [7:0]  pbyte_r,     pbyte_nxt;
  logic [7:0]  pidx_r,      pidx_nxt;

  logic [7:0]  b;
  logic [7:0]  count_inc;

  assign advance   = stage.valid && (!out_valid_r || out_ch.ready);
  assign b         = stage.item.rx_byte;
  assign count_inc = count_r + 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    sync2_nxt  = sync2_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    req_nxt    = req_r;
    ev_nxt     = EV_CONSUMED;
    pbyte_nxt  = 8'd0;
    pidx_nxt   = 8'd0;
    if (stage.item.opcode == OP_ACK) begin
      req_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_SYNC2: begin
          sync2_nxt = b;
          phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          type_nxt  = b;
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_nxt = b;
          if (((sync2_r & SYNC2_MASK) != (cfg.sync_second & SYNC2_MASK)) ||
              (b > cfg.max_length)) begin
            ev_nxt    = EV_REJECT;
            phase_nxt = PH_IDLE;
          end else if (b == 8'd0) begin
            phase_nxt = PH_TRAILER;
          end else begin
            count_nxt = 8'd0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          ev_nxt    = EV_PAYLOAD;
          pbyte_nxt = b;
          pidx_nxt  = count_r;
          count_nxt = count_inc;
          if (count_inc == length_r) begin
            phase_nxt = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          if (b == cfg.trailer_value) begin
            ev_nxt = EV_GOOD;
            if (type_r == cfg.toggle_type) begin
              req_nxt = !req_r;
            end
          end else begin
            ev_nxt = EV_BADTRL;
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = (b == cfg.sync_first) ? PH_SYNC2 : PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sync2_r     <= 8'd0;
      type_r      <= 8'd0;
      length_r    <= 8'd0;
      count_r     <= 8'd0;
      req_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r  <= phase_nxt;
        sync2_r  <= sync2_nxt;
        type_r   <= type_nxt;
        length_r <= length_nxt;
        count_r  <= count_nxt;
        req_r    <= req_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r    <= ev_nxt;
      pbyte_r <= pbyte_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  // type, length and flag are the state registers themselves: they only
  // change on advance, which is when the result register loads
  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = ev_r;
  assign out_ch.payload_byte  = pbyte_r;
  assign out_ch.payload_index = pidx_r;
  assign out_ch.frame_type    = type_r;
  assign out_ch.frame_length  = length_r;
  assign out_ch.request_flag  = req_r;
endmodule

FILE: design/sltd_checker.sv
// ----------------------------------------------------------------------------
// sltd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sync_length_trailer_deframer_macros.svh"

module sltd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic [7:0] payload_byte,
  input logic [7:0] payload_index,
  input logic [7:0] frame_length
);
  import sltd_pkg::*;

  `SLTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(payload_byte) && $stable(payload_index))
  `SLTD_ASSERT_NOW(a_event_range, out_valid, event_res <= EV_REJECT)
  `SLTD_ASSERT_NOW(a_no_payload, out_valid && (event_res != EV_PAYLOAD), (payload_byte == 8'd0) && (payload_index == 8'd0))
  `SLTD_ASSERT_NOW(a_index_bound, out_valid && (event_res == EV_PAYLOAD), (frame_length != 8'd0) && (payload_index < frame_length))
endmodule

bind sync_length_trailer_deframer sltd_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .event_res     (out_ch.event_res),
  .payload_byte  (out_ch.payload_byte),
  .payload_index (out_ch.payload_index),
  .frame_length  (out_ch.frame_length)
);
